// ----- design/windowed_batch_median_macros.svh -----
// ----------------------------------------------------------------------------
// windowed_batch_median assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_BATCH_MEDIAN_MACROS_SVH
`define WINDOWED_BATCH_MEDIAN_MACROS_SVH

`ifndef SYNTHESIS
`define WBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbm check failed");
`define WBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbm check failed");
`else
`define WBM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/wbm_pkg.sv -----
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared widths and defaults for the windowed batch median block.
// ----------------------------------------------------------------------------
package wbm_pkg;

    localparam int DATA_W       = 16;
    localparam int BIT_W        = $clog2(DATA_W);
    localparam int CNT_W        = 7;
    localparam int CNT_MAX      = (1 << CNT_W) - 1;
    localparam int CAPACITY_DEF = 64;
    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(60);

endpackage

// ----- design/wbm_ram.sv -----
// ----------------------------------------------------------------------------
// wbm_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module wbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/windowed_batch_median.sv -----
// ----------------------------------------------------------------------------
// windowed_batch_median
// Collects distance samples in a RAM and, on window close, reports the
// sample at rank count/2 (bitwise radix select) together with the count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | sink      | i_in_valid / o_in_stall    | distance_cm, close_window
//  out     | source    | o_out_valid / i_out_stall  | median_cm, sample_total
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | sample_limit
//
//  A sample without close is taken whenever the block is idle. A close runs
//  one pass per result bit, each pass reading every held entry through the
//  single RAM read port. An empty window skips the passes and goes straight to the result.
//  Synchronous active-low reset clears the count, limit (to 60) and control;
//  RAM contents are not cleared. Input is stalled during a select; a stalled
//  result stays in the output register while new samples are still taken.
// ----------------------------------------------------------------------------
`include "windowed_batch_median_macros.svh"

module windowed_batch_median #(
    parameter int CAPACITY = wbm_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [wbm_pkg::DATA_W-1:0] i_distance_cm,
    input  logic                       i_close_window,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [wbm_pkg::DATA_W-1:0] o_median_cm,
    output logic [wbm_pkg::CNT_W-1:0]  o_sample_total,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wbm_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = wbm_pkg::CNT_W;
    localparam int DATA_W  = wbm_pkg::DATA_W;
    localparam int BIT_W   = wbm_pkg::BIT_W;
    localparam int CAP_SAT = (CAPACITY > wbm_pkg::CNT_MAX) ? wbm_pkg::CNT_MAX : CAPACITY;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP_SAT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [CNT_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_tot,      n_tot;
    logic [CNT_W-1:0]  r_k,        n_k;
    logic [DATA_W-1:0] r_prefix,   n_prefix;
    logic [BIT_W-1:0]  r_bit,      n_bit;
    logic [CNT_W-1:0]  r_rd_idx,   n_rd_idx;
    logic              r_issue,    n_issue;
    logic              r_rd_pend,  n_rd_pend;
    logic              r_rd_last,  n_rd_last;
    logic [CNT_W-1:0]  r_cnt0,     n_cnt0;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_med,  n_out_med;
    logic [CNT_W-1:0]  r_out_tot,  n_out_tot;

    logic [CNT_W-1:0]  lim_eff;
    logic              in_acc;
    logic              store;
    logic [CNT_W-1:0]  new_cnt;
    logic              rd_en;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] hi_mask;
    logic              match;
    logic [CNT_W-1:0]  cnt_sum;
    logic              last_idx;

    assign lim_eff   = (r_limit > CAP_CNT) ? CAP_CNT : r_limit;
    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign store     = r_count < lim_eff;
    assign new_cnt   = r_count + CNT_W'(store);
    assign rd_en     = (r_state == ST_SCAN) && r_issue;
    assign last_idx  = r_rd_idx == (r_tot - CNT_W'(1));
    assign hi_mask   = {DATA_W{1'b1}} << ({1'b0, r_bit} + (BIT_W+1)'(1));
    assign match     = (((rd_data ^ r_prefix) & hi_mask) == '0) && !rd_data[r_bit];
    assign cnt_sum   = r_cnt0 + CNT_W'(match);

    wbm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && store),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (i_distance_cm),
        .i_rd_en   (rd_en),
        .i_rd_addr (ADDR_W'(r_rd_idx)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_tot       = r_tot;
        n_k         = r_k;
        n_prefix    = r_prefix;
        n_bit       = r_bit;
        n_rd_idx    = r_rd_idx;
        n_issue     = r_issue;
        n_rd_pend   = rd_en;
        n_rd_last   = rd_en && last_idx;
        n_cnt0      = r_cnt0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_med   = r_out_med;
        n_out_tot   = r_out_tot;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_close_window) begin
                        n_count  = '0;
                        n_tot    = new_cnt;
                        n_k      = new_cnt >> 1;
                        n_prefix = '0;
                        n_bit    = BIT_W'(DATA_W - 1);
                        n_rd_idx = '0;
                        n_issue  = 1'b1;
                        n_cnt0   = '0;
                        n_state  = (new_cnt == '0) ? ST_FIN : ST_SCAN;
                    end else begin
                        n_count = new_cnt;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    if (last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end
                end
                if (r_rd_pend) begin
                    if (r_rd_last) begin
                        // bit is 0 when enough entries sit below the target rank
                        if (cnt_sum > r_k) begin
                            n_prefix[r_bit] = 1'b0;
                        end else begin
                            n_prefix[r_bit] = 1'b1;
                            n_k             = r_k - cnt_sum;
                        end
                        n_cnt0 = '0;
                        if (r_bit == '0) begin
                            n_state = ST_FIN;
                        end else begin
                            n_bit    = r_bit - BIT_W'(1);
                            n_rd_idx = '0;
                            n_issue  = 1'b1;
                        end
                    end else begin
                        n_cnt0 = cnt_sum;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_med   = r_prefix;
                    n_out_tot   = r_tot;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_limit     <= wbm_pkg::LIMIT_RST;
            r_issue     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tot     <= n_tot;
        r_k       <= n_k;
        r_prefix  <= n_prefix;
        r_bit     <= n_bit;
        r_rd_idx  <= n_rd_idx;
        r_cnt0    <= n_cnt0;
        r_out_med <= n_out_med;
        r_out_tot <= n_out_tot;
    end

    assign o_in_stall     = r_state != ST_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_median_cm    = r_out_med;
    assign o_sample_total = r_out_tot;
    assign o_cfg_ready    = 1'b1;

    `WBM_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    `WBM_ASSERT_NOW(a_rd_in_window, i_clk, i_rst_n, rd_en, r_rd_idx < r_tot)
    `WBM_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, in_acc && i_close_window, r_count == '0)
    `WBM_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, (r_state == ST_FIN) && !r_out_valid, o_out_valid && (o_sample_total == $past(r_tot)))

endmodule

// ----- tb/windowed_batch_median_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_batch_median_test
// Self-checking bench: streams distance samples and window closes into the
// median block, predicts each close as the sample at rank count/2 of the held
// window plus the held count, and compares every output beat in order. Runs
// directed windows, then random windows under several sample limits with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module windowed_batch_median_test;

    localparam int CAP           = wbm_pkg::CAPACITY_DEF;
    localparam int DATA_W        = wbm_pkg::DATA_W;
    localparam int CNT_W         = wbm_pkg::CNT_W;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [DATA_W-1:0] median;
        logic [CNT_W-1:0]  total;
    } t_window_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [DATA_W-1:0] i_distance_cm;
    logic              i_close_window;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DATA_W-1:0] o_median_cm;
    logic [CNT_W-1:0]  o_sample_total;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;

    logic [DATA_W-1:0] window_samples [CAP];
    int unsigned       held_samples;
    logic [CNT_W-1:0]  limit_reg;
    t_window_result    pending_medians [$];

    int error_count   = 0;
    int samples_sent  = 0;
    int windows_shut  = 0;
    int beats_checked = 0;
    int full_windows  = 0;
    int empty_windows = 0;
    int limit_writes  = 0;
    int send_gap_pct  = 28;
    int out_stall_pct = 69;

    windowed_batch_median #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_distance_cm  (i_distance_cm),
        .i_close_window (i_close_window),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_cm    (o_median_cm),
        .o_sample_total (o_sample_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Sample at rank n/2 of the first n held samples; 0 for an empty window.
    function automatic logic [DATA_W-1:0] rank_median(input int unsigned n);
        logic [DATA_W-1:0] sorted [CAP];
        logic [DATA_W-1:0] v;
        int                j;
        if (n == 0) begin
            return '0;
        end
        for (int i = 0; i < n; i++) begin
            v = window_samples[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n / 2];
    endfunction

    function automatic void absorb_sample(input logic [DATA_W-1:0] sample_cm,
                                          input logic close);
        int unsigned    eff_limit;
        t_window_result r;
        eff_limit = (limit_reg > CAP) ? CAP : limit_reg;
        if (held_samples < eff_limit) begin
            window_samples[held_samples] = sample_cm;
            held_samples++;
        end
        if (close) begin
            r.median = rank_median(held_samples);
            r.total  = CNT_W'(held_samples);
            pending_medians.push_back(r);
            if (held_samples == CAP) full_windows++;
            if (held_samples == 0) empty_windows++;
            held_samples = 0;
            windows_shut++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_medians.size() == 0) begin
                $error("unexpected result beat: median_cm %0d, sample_total %0d",
                       o_median_cm, o_sample_total);
                error_count++;
            end else begin
                want = pending_medians.pop_front();
                if (o_median_cm !== want.median) begin
                    $error("median_cm: expected %0d, got %0d", want.median, o_median_cm);
                    error_count++;
                end
                if (o_sample_total !== want.total) begin
                    $error("sample_total: expected %0d, got %0d",
                           want.total, o_sample_total);
                    error_count++;
                end
                beats_checked++;
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_sample(input logic [DATA_W-1:0] sample_cm, input logic close);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_distance_cm  <= sample_cm;
        i_close_window <= close;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_sample(sample_cm, close);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_medians.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_sample_limit(input logic [CNT_W-1:0] lim);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_reg = lim;
        limit_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Runs at the reset limit of 60.
    task automatic test_small_windows();
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'd7, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'd3, 1'b0);
        send_sample(16'd9, 1'b1);
    endtask

    task automatic test_limit_drops_samples();
        write_sample_limit(CNT_W'(2));
        send_sample(16'd100, 1'b0);
        send_sample(16'd50, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd200, 1'b1);
    endtask

    task automatic test_limit_lowered_mid_window();
        write_sample_limit(wbm_pkg::LIMIT_RST);
        send_sample(16'd40, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd30, 1'b0);
        send_sample(16'd20, 1'b0);
        send_sample(16'd50, 1'b0);
        write_sample_limit(CNT_W'(1));
        send_sample(16'd0, 1'b1);
    endtask

    task automatic test_limit_zero();
        write_sample_limit('0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1234, 1'b1);
        send_sample(16'h0000, 1'b1);
    endtask

    task automatic test_random_windows(input int items, input logic [CNT_W-1:0] lim,
                                       input int gap_pct, input int stall_pct);
        int                sent;
        int                len;
        int                flavor;
        bit                first;
        logic [DATA_W-1:0] sample_cm;
        logic              close;
        sent  = 0;
        first = 1'b1;
        write_sample_limit(lim);
        send_gap_pct  = gap_pct;
        out_stall_pct = stall_pct;
        while (sent < items) begin
            if (first) begin
                len = $urandom_range(72, 65);
            end else if ($urandom_range(11) == 0) begin
                len = $urandom_range(70, 20);
            end else begin
                len = $urandom_range(12, 1);
            end
            first  = 1'b0;
            flavor = $urandom_range(3);
            for (int k = 0; k < len; k++) begin
                case (flavor)
                    0: begin
                        sample_cm = DATA_W'($urandom);
                    end
                    1: begin
                        sample_cm = DATA_W'($urandom_range(15));
                    end
                    2: begin
                        case ($urandom_range(2))
                            0: sample_cm = '0;
                            1: sample_cm = '1;
                            default: sample_cm = DATA_W'($urandom);
                        endcase
                    end
                    default: begin
                        sample_cm = 16'hFFF0 | DATA_W'($urandom_range(15));
                    end
                endcase
                // early close breaks the window short now and then
                close = (k == len - 1) || ($urandom_range(31) == 0);
                send_sample(sample_cm, close);
                sent++;
            end
            if ($urandom_range(19) == 0) wait_results_drained();
        end
        // leave a few samples held across the next limit change
        repeat ($urandom_range(3)) send_sample(DATA_W'($urandom), 1'b0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_distance_cm  = '0;
        i_close_window = 1'b0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        held_samples   = 0;
        limit_reg      = wbm_pkg::LIMIT_RST;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_small_windows();
        test_limit_drops_samples();
        test_limit_lowered_mid_window();
        test_limit_zero();

        test_random_windows(165, CNT_W'(127), 28, 69);
        test_random_windows(165, CNT_W'(1), 28, 69);
        test_random_windows(165, CNT_W'(64), 69, 28);
        test_random_windows(165, '0, 69, 28);
        test_random_windows(165, CNT_W'(65), 0, 0);
        test_random_windows(165, CNT_W'($urandom_range(63, 2)), 0, 0);

        wait_results_drained();
        repeat (32) @(negedge i_clk);
        $display("%0d samples sent, %0d windows closed, %0d result beats checked",
                 samples_sent, windows_shut, beats_checked);
        $display("%0d full-capacity windows, %0d empty windows, %0d limit writes",
                 full_windows, empty_windows, limit_writes);
        if (error_count == 0) begin
            $display("windowed_batch_median_test: PASS");
        end else begin
            $display("windowed_batch_median_test: FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("windowed_batch_median_test: FAIL");
        $finish;
    end

endmodule
